// ===== rtl/emu_pkg.sv =====
// emu_pkg: shared widths and item types for the modular exponentiation unit.
// No dependencies; imported by every module of the block.
package emu_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] exponent;
		logic [DATA_W-1:0] modulus;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] power_result;
		logic              zero_modulus;
	} out_item_t;

endpackage

// ===== rtl/emu_mulmod.sv =====
// emu_mulmod: bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
// Depends on emu_pkg for the default width.
module emu_mulmod #(
	parameter int W = emu_pkg::DATA_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] result
);
	import emu_pkg::*;

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]   dbl;
	logic [W-1:0] dbl_red;
	logic [W-1:0] addend;
	logic [W:0]   sum;
	logic [W-1:0] acc_next;

	// acc <- 2*acc mod m, then + x mod m when the multiplier bit is set
	always_comb begin
		dbl      = {acc_q, 1'b0};
		dbl_red  = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
		addend   = y_q[W-1] ? x_q : '0;
		sum      = {1'b0, dbl_red} + {1'b0, addend};
		acc_next = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= acc_next;
			y_q   <= {y_q[W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiplier restarted while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q && cnt_q == '0)) else $error("done without final step");
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start) |-> (acc_q < m)) else $error("partial product not reduced");
`endif

endmodule

// ===== rtl/modular_exponentiation_unit.sv =====
// modular_exponentiation_unit: top level, right-to-left square-and-multiply sequencer.
// Depends on emu_pkg (item types) and emu_mulmod (two bit-serial modular multipliers).

// Computes base^exponent mod modulus per item. One item is worked at a time: after the
// base is reduced by one serial pass, each exponent bit up to the highest set bit costs
// one pass of the two bit-serial multipliers running side by side, the square and the
// conditional multiply sharing the pass; the multiplier's one-bit-per-cycle loop sets
// the length of a pass. A zero modulus returns 0 with zero_modulus set, and a zero
// exponent returns 1, each without a multiplier pass. The result sits in an output
// register, so the next item is taken while it waits to be collected.
module modular_exponentiation_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  emu_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output emu_pkg::out_item_t  out_data
);
	import emu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REDUCE = 4'b0010,
		ST_EXP    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] e_q;
	logic [DATA_W-1:0] m_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] sq_q;
	logic [DATA_W-1:0] res_q;
	logic              zm_q;
	logic              start_a_q;
	logic              start_b_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              in_acc;
	logic              out_free;
	logic              done_a;
	logic              done_b;
	logic [DATA_W-1:0] res_a;
	logic [DATA_W-1:0] res_b;
	logic [DATA_W-1:0] xb;
	logic [DATA_W-1:0] yb;
	logic [DATA_W-1:0] e_next;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign e_next   = e_q >> 1;

	// Unit B reduces the base first (1 * base mod m), then does the squaring.
	assign xb = (state_q == ST_REDUCE) ? DATA_W'(1) : sq_q;
	assign yb = (state_q == ST_REDUCE) ? base_q : sq_q;

	// Unit A: running result times the current power of the base.
	emu_mulmod #(.W(DATA_W)) u_mul_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_a_q),
		.x      (acc_q),
		.y      (sq_q),
		.m      (m_q),
		.done   (done_a),
		.result (res_a)
	);

	emu_mulmod #(.W(DATA_W)) u_mul_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_b_q),
		.x      (xb),
		.y      (yb),
		.m      (m_q),
		.done   (done_b),
		.result (res_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_a_q   <= 1'b0;
			start_b_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_a_q <= 1'b0;
			start_b_q <= 1'b0;
			// drop the result once taken; a new load below overrides
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.modulus == '0 || in_data.exponent == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q   <= ST_REDUCE;
							start_b_q <= 1'b1;
						end
					end
				end
				ST_REDUCE: begin
					if (done_b) begin
						state_q   <= ST_EXP;
						start_a_q <= 1'b1;
						start_b_q <= 1'b1;
					end
				end
				ST_EXP: begin
					// advance one exponent bit per multiplier pass; stop after the top set bit
					if (done_b) begin
						if (e_next == '0) begin
							state_q <= ST_FINISH;
						end else begin
							start_a_q <= 1'b1;
							start_b_q <= 1'b1;
						end
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					base_q <= in_data.base;
					e_q    <= in_data.exponent;
					m_q    <= in_data.modulus;
					zm_q   <= (in_data.modulus == '0);
					res_q  <= (in_data.modulus == '0) ? '0 : DATA_W'(1);
				end
			end
			ST_REDUCE: begin
				if (done_b) begin
					sq_q  <= res_b;
					// 1 mod m: zero for a modulus of one
					acc_q <= (m_q == DATA_W'(1)) ? '0 : DATA_W'(1);
				end
			end
			ST_EXP: begin
				if (done_b) begin
					if (e_q[0]) begin
						acc_q <= res_a;
					end
					sq_q  <= res_b;
					e_q   <= e_next;
					res_q <= e_q[0] ? res_a : acc_q;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_q.power_result <= res_q;
					out_q.zero_modulus <= zm_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_run_nonzero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE || state_q == ST_EXP) |-> (m_q != '0))
		else $error("multiply pass with zero modulus");
	a_zero_mod_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.zero_modulus) |-> (out_q.power_result == '0))
		else $error("zero modulus with nonzero result");
	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXP) |-> (done_a == done_b))
		else $error("multipliers out of step");
`endif

endmodule
